### hw/rtl/fdsa_pkg.sv
// ----------------------------------------------------------------------------
// fdsa_pkg
// Shared types and codes for the Forth data stack with ALU: word codes,
// entry kinds, status codes and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package fdsa_pkg;

    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;
    localparam int ENTRY_W     = KIND_W + DATA_W;
    localparam int FUNC_W      = 4;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 7;

    // word codes
    localparam logic [FUNC_W-1:0] FN_ADD   = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SUB   = 4'd1;
    localparam logic [FUNC_W-1:0] FN_MUL   = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DIV   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_PRINT = 4'd4;
    localparam logic [FUNC_W-1:0] FN_DUP   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_DROP  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_SWAP  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_PUSH  = 4'd8;

    localparam logic [KIND_W-1:0] KIND_INT = 2'd0;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

    // write address select
    localparam logic [1:0] WA_TOP = 2'd0;   // n-1
    localparam logic [1:0] WA_SEC = 2'd1;   // n-2
    localparam logic [1:0] WA_NEW = 2'd2;   // n

    // write data select
    localparam logic [1:0] WD_LIT = 2'd0;
    localparam logic [1:0] WD_RES = 2'd1;
    localparam logic [1:0] WD_A   = 2'd2;   // second from top
    localparam logic [1:0] WD_B   = 2'd3;   // top

    // entry count update
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC1 = 2'd2;
    localparam logic [1:0] CNT_DEC2 = 2'd3;

    typedef struct packed {
        logic                ld_item;
        logic                rd_en;
        logic                st_ld;
        logic [STATUS_W-1:0] st_code;
        logic                prt_ld;
        logic                res_ld;
        logic                div_start;
        logic                wr_en;
        logic [1:0]          wr_addr;
        logic [1:0]          wr_data;
        logic [1:0]          cnt_op;
        logic                out_ld;
    } fdsa_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              n_zero;
        logic              n_lt2;
        logic              n_full;
        logic              both_int;
        logic              b_zero;
        logic              div_done;
        logic              out_busy;
    } fdsa_sts_t;

endpackage

### hw/rtl/forth_data_stack_alu.sv
// ----------------------------------------------------------------------------
// forth_data_stack_alu
// Forth data stack of typed entries with an integer ALU, one word per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one beat per word (opcode and literal kind in
//   s_tuser, literal value in s_tdata). Master channel m_*: exactly one
//   result beat per word with the print data, status and new depth.
//   Words are handled one at a time; s_tready is high only while the
//   sequencer is idle.
//   Words that end at decode (push, underflow, overflow, dup on empty,
//   spare codes) go straight to the result; print, drop, dup, divide by
//   zero and mixed kinds add an operand read; add, sub, mul and swap add
//   a write state (S_WRA or S_SWP2) after it; divide waits in S_DIVW for
//   the one-bit-per-cycle divider. s_tready rises with the result.
//   The result sits in an output register, so the next word is accepted
//   while it waits; a word finishing while that register is still held
//   waits for m_tready before handing off.
//   Reset empties the stack (entry count to zero) and clears the output
//   valid; stack memory contents are not cleared and are never used
//   before being written.
// ----------------------------------------------------------------------------
module forth_data_stack_alu
    import fdsa_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] lit_value
    input  logic [5:0]  s_tuser,    // [3:0] func, [5:4] lit_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [31:0] print_value, [33:32] status,
                                    // [40:34] stack_depth, [47:41] zero
    output logic [2:0]  m_tuser     // [0] print_valid, [2:1] print_kind
);

    fdsa_cmd_t cmd;
    fdsa_sts_t sts;

    logic                   print_valid;
    logic [KIND_W-1:0]      print_kind;
    logic [DATA_W-1:0]      print_value;
    logic [STATUS_W-1:0]    status;
    logic [DEPTH_OUT_W-1:0] stack_depth;

    fdsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fdsa_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_func         (s_tuser[3:0]),
        .in_kind         (s_tuser[5:4]),
        .in_value        (s_tdata),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_print_valid (print_valid),
        .out_print_kind  (print_kind),
        .out_print_value (print_value),
        .out_status      (status),
        .out_depth       (stack_depth)
    );

    assign m_tdata = {7'd0, stack_depth, status, print_value};
    assign m_tuser = {print_kind, print_valid};

endmodule

### hw/rtl/fdsa_div.sv
// ----------------------------------------------------------------------------
// fdsa_div
// Signed 32-bit divider, truncating toward zero. Restoring radix-2, one
// quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module fdsa_div
    import fdsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    assign rem_sh = {rem_reg, quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DATA_W - 1);
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_next  = diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_next  = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

### hw/rtl/fdsa_dp.sv
// ----------------------------------------------------------------------------
// fdsa_dp
// Datapath: stack memory with two registered read ports and one write
// port, entry count, ALU with divider, and the output register.
// ----------------------------------------------------------------------------
module fdsa_dp
    import fdsa_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  fdsa_cmd_t           cmd,
    output fdsa_sts_t           sts,
    input  logic [FUNC_W-1:0]   in_func,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [DATA_W-1:0]   in_value,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_print_valid,
    output logic [KIND_W-1:0]   out_print_kind,
    output logic [DATA_W-1:0]   out_print_value,
    output logic [STATUS_W-1:0] out_status,
    output logic [DEPTH_OUT_W-1:0] out_depth
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int XW = (CW > DEPTH_OUT_W) ? CW : DEPTH_OUT_W;

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];

    logic [FUNC_W-1:0]   func_reg;
    logic [KIND_W-1:0]   lkind_reg;
    logic [DATA_W-1:0]   lval_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [ENTRY_W-1:0]  rd_a_reg, rd_b_reg;
    logic [DATA_W-1:0]   res_reg;
    logic                pvalid_reg;
    logic [KIND_W-1:0]   pkind_reg;
    logic [DATA_W-1:0]   pval_reg;
    logic [STATUS_W-1:0] st_reg;
    logic                ovalid_reg, ovalid_next;
    logic                opv_reg;
    logic [KIND_W-1:0]   opk_reg;
    logic [DATA_W-1:0]   opval_reg;
    logic [STATUS_W-1:0] ost_reg;
    logic [DEPTH_OUT_W-1:0] odepth_reg;

    logic [AW-1:0]      addr_top, addr_sec, addr_new, wr_addr;
    logic [CW-1:0]      cnt_m1, cnt_m2;
    logic [ENTRY_W-1:0] wr_data;
    logic [DATA_W-1:0]  a_val, b_val, alu_res, mul_lo, div_q;
    logic               div_done;
    logic [XW-1:0]      cnt_x;

    assign cnt_m1   = cnt_reg - CW'(1);
    assign cnt_m2   = cnt_reg - CW'(2);
    assign addr_top = cnt_m1[AW-1:0];
    assign addr_sec = cnt_m2[AW-1:0];
    assign addr_new = cnt_reg[AW-1:0];

    assign a_val = rd_a_reg[DATA_W-1:0];
    assign b_val = rd_b_reg[DATA_W-1:0];

    always_comb
    begin
        case (cmd.wr_addr)
            WA_TOP:  wr_addr = addr_top;
            WA_SEC:  wr_addr = addr_sec;
            default: wr_addr = addr_new;
        endcase
        case (cmd.wr_data)
            WD_LIT:  wr_data = {lkind_reg, lval_reg};
            WD_RES:  wr_data = {KIND_INT, res_reg};
            WD_A:    wr_data = rd_a_reg;
            default: wr_data = rd_b_reg;
        endcase
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[addr_sec];
            rd_b_reg <= mem[addr_top];
        end
    end

    fdsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_val),
        .divisor  (b_val),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mul_lo = a_val * b_val;

    always_comb
    begin
        case (func_reg)
            FN_ADD:  alu_res = a_val + b_val;
            FN_SUB:  alu_res = a_val - b_val;
            FN_MUL:  alu_res = mul_lo;
            default: alu_res = div_q;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC:  cnt_next = cnt_reg + CW'(1);
            CNT_DEC1: cnt_next = cnt_m1;
            CNT_DEC2: cnt_next = cnt_m2;
            default:  cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.out_ld)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            func_reg   <= in_func;
            lkind_reg  <= in_kind;
            lval_reg   <= in_value;
            pvalid_reg <= 1'b0;
            pkind_reg  <= '0;
            pval_reg   <= '0;
            st_reg     <= ST_OK;
        end
        else
        begin
            if (cmd.st_ld)
                st_reg <= cmd.st_code;
            if (cmd.prt_ld)
            begin
                pvalid_reg <= 1'b1;
                pkind_reg  <= rd_b_reg[ENTRY_W-1:DATA_W];
                pval_reg   <= b_val;
            end
        end
        if (cmd.res_ld)
            res_reg <= alu_res;
        if (cmd.out_ld)
        begin
            opv_reg    <= pvalid_reg;
            opk_reg    <= pkind_reg;
            opval_reg  <= pval_reg;
            ost_reg    <= st_reg;
            odepth_reg <= cnt_x[DEPTH_OUT_W-1:0];
        end
    end

    assign cnt_x = XW'(cnt_reg);

    assign sts.func     = func_reg;
    assign sts.n_zero   = (cnt_reg == '0);
    assign sts.n_lt2    = (cnt_reg < CW'(2));
    assign sts.n_full   = (cnt_reg >= CW'(STACK_DEPTH));
    assign sts.both_int = (rd_a_reg[ENTRY_W-1:DATA_W] == KIND_INT)
                        && (rd_b_reg[ENTRY_W-1:DATA_W] == KIND_INT);
    assign sts.b_zero   = (b_val == '0);
    assign sts.div_done = div_done;
    assign sts.out_busy = ovalid_reg & ~out_ready;

    assign out_valid       = ovalid_reg;
    assign out_print_valid = opv_reg;
    assign out_print_kind  = opk_reg;
    assign out_print_value = opval_reg;
    assign out_status      = ost_reg;
    assign out_depth       = odepth_reg;

endmodule

### hw/rtl/fdsa_ctrl.sv
// ----------------------------------------------------------------------------
// fdsa_ctrl
// Word sequencer: decodes one word at a time, checks depth limits, steps
// the datapath through read, compute, write-back and result hand-off.
// ----------------------------------------------------------------------------
module fdsa_ctrl
    import fdsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fdsa_sts_t sts,
    output fdsa_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_OPS    = 3'd2;
    localparam logic [2:0] S_DIVW   = 3'd3;
    localparam logic [2:0] S_WRA    = 3'd4;
    localparam logic [2:0] S_SWP2   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (sts.func)
                    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_SWAP:
                    begin
                        if (sts.n_lt2)
                        begin
                            cmd.st_ld   = 1'b1;
                            cmd.st_code = ST_UNDER;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_OPS;
                        end
                    end
                    FN_PRINT, FN_DROP:
                    begin
                        if (sts.n_zero)
                        begin
                            cmd.st_ld   = 1'b1;
                            cmd.st_code = ST_UNDER;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_OPS;
                        end
                    end
                    FN_DUP:
                    begin
                        // dup on an empty stack is a no-op
                        if (!sts.n_zero)
                        begin
                            if (sts.n_full)
                            begin
                                cmd.st_ld   = 1'b1;
                                cmd.st_code = ST_OVER;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                state_next = S_OPS;
                            end
                        end
                    end
                    FN_PUSH:
                    begin
                        if (sts.n_full)
                        begin
                            cmd.st_ld   = 1'b1;
                            cmd.st_code = ST_OVER;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = WA_NEW;
                            cmd.wr_data = WD_LIT;
                            cmd.cnt_op  = CNT_INC;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_OPS:
            begin
                state_next = S_DONE;
                case (sts.func)
                    FN_SWAP:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = WA_TOP;
                        cmd.wr_data = WD_A;
                        state_next  = S_SWP2;
                    end
                    FN_PRINT:
                    begin
                        cmd.prt_ld = 1'b1;
                        cmd.cnt_op = CNT_DEC1;
                    end
                    FN_DROP:
                    begin
                        cmd.cnt_op = CNT_DEC1;
                    end
                    FN_DUP:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = WA_NEW;
                        cmd.wr_data = WD_B;
                        cmd.cnt_op  = CNT_INC;
                    end
                    default:
                    begin
                        // arithmetic: mixed kinds discard both operands
                        if (!sts.both_int)
                            cmd.cnt_op = CNT_DEC2;
                        else if (sts.func == FN_DIV)
                        begin
                            if (sts.b_zero)
                            begin
                                cmd.st_ld   = 1'b1;
                                cmd.st_code = ST_DIVZERO;
                            end
                            else
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = S_DIVW;
                            end
                        end
                        else
                        begin
                            cmd.res_ld = 1'b1;
                            state_next = S_WRA;
                        end
                    end
                endcase
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    cmd.res_ld = 1'b1;
                    state_next = S_WRA;
                end
            end
            S_WRA:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = WA_SEC;
                cmd.wr_data = WD_RES;
                cmd.cnt_op  = CNT_DEC1;
                state_next  = S_DONE;
            end
            S_SWP2:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = WA_SEC;
                cmd.wr_data = WD_B;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/fdsa_chk.sv
// ----------------------------------------------------------------------------
// fdsa_chk
// Port-level checker for the Forth data stack, bound to the top level.
// ----------------------------------------------------------------------------
module fdsa_chk
    import fdsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // held result beat stays up
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one word in flight: input closes right after a beat is taken
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    // a printing word always completes with ok status
    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[33:32] == ST_OK)
        else $error("print beat with error status");

    a_noprint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == 2'd0 && m_tdata[31:0] == 32'd0)
        else $error("print fields set on non-print beat");

endmodule

bind forth_data_stack_alu fdsa_chk u_fdsa_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/forth_data_stack_alu_tb.sv
// ----------------------------------------------------------------------------
// forth_data_stack_alu_tb
// Self-checking bench for the Forth data stack ALU. Words go in on the
// s_* stream and each one predicts one result beat on m_* from a local model
// of the stack. Directed words cover the edge cases; random words in fill,
// drain and mixed phases push the stack from empty to full and back, with
// random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module forth_data_stack_alu_tb;
    import fdsa_pkg::*;

    localparam int STACK_DEPTH    = 64;
    localparam int RANDOM_WORDS   = 1550;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int REPORT_MAX     = 10;
    localparam int IDLE_PCT       = 24;
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = FN_PUSH + 1;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'hF;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    typedef struct packed {
        logic                   print_valid;
        logic [KIND_W-1:0]      print_kind;
        logic [DATA_W-1:0]      print_value;
        logic [STATUS_W-1:0]    status;
        logic [DEPTH_OUT_W-1:0] stack_depth;
    } word_result_t;

    class stack_result_board;
        logic [ENTRY_W-1:0] entries [STACK_DEPTH];
        int unsigned        entry_count = 0;
        word_result_t       expected_q [$];
        int unsigned        fail_count = 0;

        // run one word against the local stack and queue the result it owes
        function void note_word(logic [FUNC_W-1:0] func, logic [KIND_W-1:0] kind,
                                logic [DATA_W-1:0] value);
            word_result_t      r;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] q;
            logic [ENTRY_W-1:0] t;
            int unsigned       n;
            r = '0;
            r.status = ST_OK;
            n = entry_count;
            case (func)
                FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                begin
                    if (n < 2)
                    begin
                        r.status = ST_UNDER;
                    end
                    else if (entries[n-2][ENTRY_W-1:DATA_W] == KIND_INT &&
                             entries[n-1][ENTRY_W-1:DATA_W] == KIND_INT)
                    begin
                        a = entries[n-2][DATA_W-1:0];
                        b = entries[n-1][DATA_W-1:0];
                        if (func == FN_DIV && b == '0)
                        begin
                            r.status = ST_DIVZERO;
                        end
                        else
                        begin
                            case (func)
                                FN_ADD: q = a + b;
                                FN_SUB: q = a - b;
                                FN_MUL: q = a * b;
                                // 64-bit divide so min / -1 wraps instead of trapping
                                default: q = 32'(longint'($signed(a)) / longint'($signed(b)));
                            endcase
                            entries[n-2] = {KIND_INT, q};
                            n = n - 1;
                        end
                    end
                    else
                    begin
                        n = n - 2;  // mixed kinds: both operands dropped
                    end
                end
                FN_PRINT, FN_DROP:
                begin
                    if (n == 0)
                    begin
                        r.status = ST_UNDER;
                    end
                    else
                    begin
                        if (func == FN_PRINT)
                        begin
                            r.print_valid = 1'b1;
                            r.print_kind  = entries[n-1][ENTRY_W-1:DATA_W];
                            r.print_value = entries[n-1][DATA_W-1:0];
                        end
                        n = n - 1;
                    end
                end
                FN_DUP:
                begin
                    if (n != 0)
                    begin
                        if (n >= STACK_DEPTH)
                        begin
                            r.status = ST_OVER;
                        end
                        else
                        begin
                            entries[n] = entries[n-1];
                            n = n + 1;
                        end
                    end
                end
                FN_SWAP:
                begin
                    if (n < 2)
                    begin
                        r.status = ST_UNDER;
                    end
                    else
                    begin
                        t            = entries[n-1];
                        entries[n-1] = entries[n-2];
                        entries[n-2] = t;
                    end
                end
                FN_PUSH:
                begin
                    if (n >= STACK_DEPTH)
                    begin
                        r.status = ST_OVER;
                    end
                    else
                    begin
                        entries[n] = {kind, value};
                        n = n + 1;
                    end
                end
                default:
                begin
                end
            endcase
            entry_count   = n;
            r.stack_depth = DEPTH_OUT_W'(n);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [47:0] tdata, logic [2:0] tuser);
            word_result_t got;
            word_result_t want;
            got.print_value = tdata[31:0];
            got.status      = tdata[33:32];
            got.stack_depth = tdata[40:34];
            got.print_valid = tuser[0];
            got.print_kind  = tuser[2:1];
            if (expected_q.size() == 0)
            begin
                if (fail_count < REPORT_MAX)
                    $display("unexpected result beat: pv=%0d pk=%0d val=%h st=%0d depth=%0d",
                             got.print_valid, got.print_kind, got.print_value,
                             got.status, got.stack_depth);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.print_valid !== want.print_valid ||
                    got.print_kind  !== want.print_kind  ||
                    got.print_value !== want.print_value ||
                    got.status      !== want.status      ||
                    got.stack_depth !== want.stack_depth)
                begin
                    if (fail_count < REPORT_MAX)
                        $display({"result mismatch: expected pv=%0d pk=%0d val=%h st=%0d ",
                                  "depth=%0d, actual pv=%0d pk=%0d val=%h st=%0d depth=%0d"},
                                 want.print_valid, want.print_kind, want.print_value,
                                 want.status, want.stack_depth,
                                 got.print_valid, got.print_kind, got.print_value,
                                 got.status, got.stack_depth);
                    fail_count++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [5:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    stack_result_board board;
    bit                steady_flow;
    int unsigned       cycle_count;

    forth_data_stack_alu #(
        .STACK_DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL forth_data_stack_alu");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [KIND_W-1:0] kind,
                             input logic [DATA_W-1:0] value);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {kind, func};
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_word(func, kind, value);
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_int();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5, 6, 7: return 32'(int'($urandom_range(16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(int phase);
        int t [6];
        int r;
        case (phase)
            PH_FILL:  t = '{50, 65, 75, 82, 88, 95};
            PH_DRAIN: t = '{15, 20, 55, 68, 80, 92};
            default:  t = '{35, 42, 70, 78, 85, 95};
        endcase
        r = $urandom_range(99);
        if (r < t[0]) return FN_PUSH;
        if (r < t[1]) return FN_DUP;
        if (r < t[2])
        begin
            case ($urandom_range(3))
                0: return FN_ADD;
                1: return FN_SUB;
                2: return FN_MUL;
                default: return FN_DIV;
            endcase
        end
        if (r < t[3]) return FN_PRINT;
        if (r < t[4]) return FN_DROP;
        if (r < t[5]) return FN_SWAP;
        return FN_SPARE_LO + FUNC_W'($urandom_range(FN_SPARE_HI - FN_SPARE_LO));
    endfunction

    task automatic send_random_word(input int phase);
        logic [FUNC_W-1:0] func;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        func = pick_func(phase);
        if (func == FN_PUSH)
        begin
            // mostly integers so arithmetic gets exercised
            kind = ($urandom_range(99) < 80) ? KIND_INT : KIND_W'($urandom_range(3, 1));
            if (kind == KIND_INT)
                value = pick_int();
            else if (kind == 2'd2)
                value = 32'($urandom_range(1));
            else
                value = $urandom;
        end
        else
        begin
            kind  = KIND_W'($urandom_range(3));
            value = $urandom;
        end
        send_word(func, kind, value);
    endtask

    initial
    begin
        int phase;
        board       = new;
        steady_flow = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // underflow on an empty stack, and dup on empty is a quiet no-op
        send_word(FN_ADD,   KIND_INT, 32'h0);
        send_word(FN_PRINT, KIND_INT, 32'h0);
        send_word(FN_DROP,  KIND_INT, 32'h0);
        send_word(FN_SWAP,  KIND_INT, 32'h0);
        send_word(FN_DUP,   KIND_INT, 32'h0);
        send_word(FN_DIV,   KIND_INT, 32'h0);
        // add wraps at the top of the range
        send_word(FN_PUSH,  KIND_INT, 32'h7FFF_FFFF);
        send_word(FN_PUSH,  KIND_INT, 32'h1);
        send_word(FN_ADD,   KIND_INT, 32'h0);
        // most negative over minus one wraps back to itself
        send_word(FN_PUSH,  KIND_INT, 32'hFFFF_FFFF);
        send_word(FN_DIV,   KIND_INT, 32'h0);
        // divide by zero leaves both operands in place
        send_word(FN_PUSH,  KIND_INT, 32'h0);
        send_word(FN_DIV,   KIND_INT, 32'h0);
        send_word(FN_SWAP,  KIND_INT, 32'h0);
        send_word(FN_SUB,   KIND_INT, 32'h0);
        send_word(FN_PUSH,  KIND_INT, 32'hFFFF_FFFD);
        send_word(FN_MUL,   KIND_INT, 32'h0);
        // handle mixed with an integer: both dropped
        send_word(FN_PUSH,  2'd1,     32'hDEAD_BEEF);
        send_word(FN_ADD,   KIND_INT, 32'h0);
        // kind three is kept and printed as is
        send_word(FN_PUSH,  2'd3,     32'hFFFF_FFFF);
        send_word(FN_DUP,   KIND_INT, 32'h0);
        send_word(FN_PRINT, KIND_INT, 32'h0);
        send_word(FN_PUSH,  2'd2,     32'h1);
        send_word(FN_SPARE_LO, 2'd3,  32'hFFFF_FFFF);
        send_word(FN_SPARE_HI, 2'd3,  32'hFFFF_FFFF);

        phase = PH_FILL;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 80 == 0 && i != 0)
                phase = $urandom_range(2);
            steady_flow = (i >= 700 && i < 1000);
            send_random_word(phase);
        end
        s_tvalid    <= 1'b0;
        steady_flow = 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.fail_count == 0)
            $display("PASS forth_data_stack_alu");
        else
            $display("FAIL forth_data_stack_alu");
        $finish;
    end

endmodule
